### hw/rtl/ncrmt_pkg.sv
// ----------------------------------------------------------------------------
// ncrmt_pkg: shared types and constants
// Field widths, operation and status codes for the network claim table.
// ----------------------------------------------------------------------------
`default_nettype none

package ncrmt_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned OwnerBitsDef    = 8;

  localparam logic [7:0] DomIpv4    = 8'd2;
  localparam logic [7:0] DomIpv6    = 8'd28;
  localparam logic [1:0] DirAny     = 2'd3;
  localparam logic [7:0] PrefixFull = 8'd128;

  localparam logic [2:0] FuncCheck   = 3'd0;
  localparam logic [2:0] FuncSocket  = 3'd1;
  localparam logic [2:0] FuncClaim   = 3'd2;
  localparam logic [2:0] FuncRelease = 3'd3;
  localparam logic [2:0] FuncRevoke  = 3'd4;

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StDenied      = 3'd1;
  localparam logic [2:0] StBusy        = 3'd2;
  localparam logic [2:0] StNotFound    = 3'd3;
  localparam logic [2:0] StInvalid     = 3'd4;
  localparam logic [2:0] StNoNonce     = 3'd5;
  localparam logic [2:0] StFull        = 3'd6;
  localparam logic [2:0] StUnsupported = 3'd7;

  // Claim key: domain, protocol, port, direction, prefix.
  typedef struct packed {
    logic [7:0]  domain;
    logic [7:0]  protocol;
    logic [15:0] port;
    logic [1:0]  direction;
    logic [7:0]  prefix;
  } key_t;

  // Mask with the top p bits of a 128-bit address set (p in 0..128).
  function automatic logic [127:0] pfx_mask(input logic [7:0] p);
    logic [127:0] m;
    m = '1;
    if (p >= PrefixFull) begin
      pfx_mask = m;
    end else begin
      pfx_mask = ~(m >> p);
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/network_claim_rule_match_table.sv
// ----------------------------------------------------------------------------
// network_claim_rule_match_table: claim table with wildcard and CIDR matching
// Each accepted operation sweeps the claim memory once, one entry a cycle,
// through a registered read port; a claim with no conflict sweeps it twice,
// and a rejected request skips the sweep. One item at a time. Reset clears
// all valid bits and the fill count; the claim memory needs none.
// ----------------------------------------------------------------------------
`default_nettype none

module network_claim_rule_match_table
  import ncrmt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned OWNER_BITS    = OwnerBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[2:0], instance_req[10:3], nonce[74:11], domain[82:75],
  // protocol[90:83], port[106:91], direction[108:107], prefix[116:109],
  // addr_hi[180:117], addr_lo[244:181], zero fill to 248
  input  wire logic [247:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], entries_used[9:3], zero fill to 16
  output logic [15:0]       m_axis_tdata
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SScan2 = 3'd2;
  localparam logic [2:0] SDone  = 3'd3;

  typedef struct packed {
    key_t                  key;
    logic [127:0]          addr;
    logic [63:0]           nonce;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  // Claim memory and its valid bits.
  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t                   rd_q;

  logic [2:0]          state_q;
  logic [CntW-1:0]     rd_cnt_q;      // address issued
  logic [CntW-1:0]     cmp_cnt_q;     // entry in rd_q
  logic                rd_v_q;
  logic [CntW-1:0]     used_q;
  logic [2:0]          status_q;
  logic                found_q, mine_q, hit_q, free_q;
  logic [IdxW-1:0]     hit_idx_q, free_idx_q;

  // Request registers.
  logic [2:0]            func_q;
  logic [OWNER_BITS-1:0] inst_q;
  logic [63:0]           nonce_q;
  key_t                  key_q;
  logic [127:0]          addr_q, chk_addr_q;
  logic                  has_q;
  logic [15:0]           chk_port_q;

  // Input field split.
  logic [2:0]   in_func;
  logic [7:0]   in_inst, in_dom, in_proto, in_pfx;
  logic [63:0]  in_nonce, in_hi, in_lo;
  logic [15:0]  in_port;
  logic [1:0]   in_dir;
  assign in_func  = s_axis_tdata[2:0];
  assign in_inst  = s_axis_tdata[10:3];
  assign in_nonce = s_axis_tdata[74:11];
  assign in_dom   = s_axis_tdata[82:75];
  assign in_proto = s_axis_tdata[90:83];
  assign in_port  = s_axis_tdata[106:91];
  assign in_dir   = s_axis_tdata[108:107];
  assign in_pfx   = s_axis_tdata[116:109];
  assign in_hi    = s_axis_tdata[180:117];
  assign in_lo    = s_axis_tdata[244:181];

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tdata  = {6'd0, 7'(used_q), status_q};

  // Per-entry match terms on the registered read.
  logic          e_valid;
  logic [7:0]    e_pfx, r_pfx, norm_e, norm_r, mp;
  logic          e_wild, chk_m, sock_m, ovl_m, exact_m, nonce_eq;
  logic [127:0]  diff;
  logic          chk_addr_ok;
  logic          any_m, own_m;

  always_comb begin
    e_valid  = rd_v_q && valid_q[cmp_cnt_q[IdxW-1:0]];
    e_pfx    = rd_q.key.prefix;
    r_pfx    = key_q.prefix;
    e_wild   = (rd_q.addr == '0);
    nonce_eq = (rd_q.nonce == nonce_q);
    diff     = rd_q.addr ^ chk_addr_q;
    if (e_wild) begin
      chk_addr_ok = 1'b1;
    end else if (!has_q) begin
      chk_addr_ok = 1'b0;
    end else if (e_pfx == 8'd0 || e_pfx >= PrefixFull) begin
      chk_addr_ok = (diff == '0);
    end else begin
      chk_addr_ok = ((diff & pfx_mask(e_pfx)) == '0);
    end
    chk_m = e_valid && ((rd_q.key.direction & key_q.direction) != 2'd0)
         && (rd_q.key.domain == 8'd0 || rd_q.key.domain == key_q.domain)
         && (rd_q.key.protocol == 8'd0 || rd_q.key.protocol == key_q.protocol)
         && (rd_q.key.port == 16'd0 || rd_q.key.port == chk_port_q)
         && chk_addr_ok;
    sock_m = e_valid
         && (rd_q.key.domain == 8'd0 || rd_q.key.domain == key_q.domain)
         && (rd_q.key.protocol == 8'd0 || rd_q.key.protocol == key_q.protocol)
         && rd_q.key.port == 16'd0 && rd_q.key.direction == DirAny && e_wild;
    // Match on the entry in hand for an access or socket check.
    any_m  = (func_q == FuncCheck) ? chk_m : sock_m;
    own_m  = any_m && (nonce_q != 64'd0) && nonce_eq;
    norm_e = (e_pfx == 8'd0 || e_pfx > PrefixFull) ? PrefixFull : e_pfx;
    norm_r = (r_pfx == 8'd0 || r_pfx > PrefixFull) ? PrefixFull : r_pfx;
    mp     = (norm_r < norm_e) ? norm_r : norm_e;
    ovl_m  = e_valid
         && (rd_q.key.port == 16'd0 || key_q.port == 16'd0 || rd_q.key.port == key_q.port)
         && (rd_q.key.domain == 8'd0 || key_q.domain == 8'd0
             || rd_q.key.domain == key_q.domain)
         && ((rd_q.key.direction & key_q.direction) != 2'd0)
         && (rd_q.key.protocol == 8'd0 || key_q.protocol == 8'd0
             || rd_q.key.protocol == key_q.protocol)
         && (e_wild || addr_q == '0
             || (((rd_q.addr ^ addr_q) & pfx_mask(mp)) == '0));
    exact_m = e_valid && nonce_eq && rd_q.key == key_q && rd_q.addr == addr_q;
  end

  logic scan_end;
  assign scan_end = rd_v_q && (cmp_cnt_q == CntW'(TABLE_ENTRIES - 1));

  // Memory read port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_cnt_q[IdxW-1:0]];
  end

  // Memory write port: insert on claim.
  logic          wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t        wr_data;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      valid_q       <= '0;
      used_q        <= '0;
      rd_cnt_q      <= '0;
      cmp_cnt_q     <= '0;
      rd_v_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      status_q      <= StOk;
      found_q       <= 1'b0;
      mine_q        <= 1'b0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      hit_idx_q     <= '0;
      free_idx_q    <= '0;
      func_q        <= FuncCheck;
      inst_q        <= '0;
      nonce_q       <= '0;
      key_q         <= '0;
      addr_q        <= '0;
      chk_addr_q    <= '0;
      has_q         <= 1'b0;
      chk_port_q    <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            func_q    <= in_func;
            inst_q    <= OWNER_BITS'(in_inst);
            nonce_q   <= in_nonce;
            key_q     <= '{in_dom, in_proto, in_port, in_dir, in_pfx};
            addr_q    <= {in_hi, in_lo};
            found_q   <= 1'b0;
            mine_q    <= 1'b0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            rd_cnt_q  <= '0;
            rd_v_q    <= 1'b0;
            if (in_dom == DomIpv4) begin
              chk_addr_q <= {64'd0, 32'h0000ffff, in_lo[31:0]};
              has_q      <= 1'b1;
              chk_port_q <= in_port;
            end else if (in_dom == DomIpv6) begin
              chk_addr_q <= {in_hi, in_lo};
              has_q      <= 1'b1;
              chk_port_q <= in_port;
            end else begin
              chk_addr_q <= '0;
              has_q      <= 1'b0;
              chk_port_q <= 16'd0;
            end
            if (in_func > FuncRevoke) begin
              status_q <= StUnsupported;
              state_q  <= SDone;
            end else if ((in_func inside {FuncClaim, FuncRelease})
                         && in_nonce == 64'd0) begin
              status_q <= StNoNonce;
              state_q  <= SDone;
            end else if ((in_func inside {FuncClaim, FuncRelease})
                         && (in_dir == 2'd0 || in_pfx > PrefixFull)) begin
              status_q <= StInvalid;
              state_q  <= SDone;
            end else begin
              state_q <= SScan;
            end
          end
        end
        SScan, SScan2: begin
          // Issue reads, then compare one entry a cycle.
          if (rd_cnt_q != CntW'(TABLE_ENTRIES)) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          rd_v_q    <= (rd_cnt_q != CntW'(TABLE_ENTRIES));
          cmp_cnt_q <= rd_cnt_q;
          if (state_q == SScan) begin
            case (func_q)
              FuncCheck: begin
                if (chk_m) begin
                  if (nonce_q != 64'd0 && nonce_eq) mine_q <= 1'b1;
                  else found_q <= 1'b1;
                end
              end
              FuncSocket: begin
                if (sock_m) begin
                  if (nonce_q != 64'd0 && nonce_eq) mine_q <= 1'b1;
                  else found_q <= 1'b1;
                end
              end
              FuncClaim: begin
                if (ovl_m && !nonce_eq) found_q <= 1'b1;
                if (rd_v_q && !valid_q[cmp_cnt_q[IdxW-1:0]] && !free_q) begin
                  free_q     <= 1'b1;
                  free_idx_q <= cmp_cnt_q[IdxW-1:0];
                end
              end
              FuncRelease: begin
                if (exact_m && rd_q.owner == inst_q && !hit_q) begin
                  hit_q     <= 1'b1;
                  hit_idx_q <= cmp_cnt_q[IdxW-1:0];
                end
              end
              default: begin
                if (e_valid && rd_q.owner == inst_q) begin
                  valid_q[cmp_cnt_q[IdxW-1:0]] <= 1'b0;
                  used_q <= used_q - 1'b1;
                end
              end
            endcase
            if (scan_end) begin
              case (func_q)
                FuncCheck, FuncSocket: begin
                  // The last entry counts alongside the flags gathered so far.
                  status_q <= ((found_q || (any_m && !own_m)) && !(mine_q || own_m))
                              ? StDenied : StOk;
                  state_q  <= SDone;
                end
                FuncClaim: begin
                  if (found_q || (ovl_m && !nonce_eq)) begin
                    status_q <= StBusy;
                    state_q  <= SDone;
                  end else begin
                    rd_cnt_q <= '0;
                    state_q  <= SScan2;
                  end
                end
                FuncRelease: begin
                  if (hit_q || (exact_m && rd_q.owner == inst_q)) begin
                    valid_q[hit_q ? hit_idx_q : cmp_cnt_q[IdxW-1:0]] <= 1'b0;
                    used_q   <= used_q - 1'b1;
                    status_q <= StOk;
                  end else begin
                    status_q <= StNotFound;
                  end
                  state_q <= SDone;
                end
                default: begin
                  status_q <= StOk;
                  state_q  <= SDone;
                end
              endcase
            end
          end else begin
            // Second sweep of a claim: look for a same-nonce duplicate.
            if (exact_m && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= cmp_cnt_q[IdxW-1:0];
            end
            if (scan_end) begin
              if (hit_q || exact_m) begin
                status_q <= StOk;
              end else if (free_q) begin
                valid_q[free_idx_q] <= 1'b1;
                used_q   <= used_q + 1'b1;
                status_q <= StOk;
              end else begin
                status_q <= StFull;
              end
              state_q <= SDone;
            end
          end
        end
        SDone: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q       <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Write-back: new claim into the free slot, or owner update on re-claim.
  logic reclaim_now;
  assign reclaim_now = (state_q == SScan2) && scan_end && (hit_q || exact_m);
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = free_idx_q;
    wr_data = '{key_q, addr_q, nonce_q, inst_q};
    if (reclaim_now) begin
      wr_en  = 1'b1;
      wr_idx = hit_q ? hit_idx_q : cmp_cnt_q[IdxW-1:0];
      // Same key, address and nonce; only the owner changes.
    end else if ((state_q == SScan2) && scan_end && free_q) begin
      wr_en = 1'b1;
    end
  end

endmodule

`default_nettype wire
